### design/elt_pkg.sv
package elt_pkg;

	// Ring depths; both must be powers of two (index arithmetic wraps by truncation).
	localparam int ERR_DEPTH  = 32;
	localparam int CRIT_DEPTH = 8;
	localparam int ERR_AW     = $clog2(ERR_DEPTH);
	localparam int CRIT_AW    = $clog2(CRIT_DEPTH);
	localparam int CRIT_CW    = $clog2(CRIT_DEPTH + 1);

	// Fixed field widths.
	localparam int CODE_W  = 32;
	localparam int STAMP_W = 32;
	localparam int AGE_W   = 5;
	localparam int KIND_W  = 3;
	localparam int UNIQ_W  = 9;
	localparam int FILL_W  = 6;
	localparam int SEEN_W  = 8;
	localparam int SEEN_N  = 1 << SEEN_W;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOG       = 3'd0,
		KIND_LOG_CRIT  = 3'd1,
		KIND_READ      = 3'd2,
		KIND_READ_CRIT = 3'd3,
		KIND_CLEAR     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [CODE_W-1:0]  code;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [31:0]        total;
		logic [UNIQ_W-1:0]  uniq;
		logic [31:0]        crit;
		logic [STAMP_W-1:0] last;
		logic [STAMP_W-1:0] oldest;
		logic [FILL_W-1:0]  fill;
	} stats_t;

endpackage

### design/error_log_tracker_unit.sv
// Error log tracker.
// Input channel (in_valid/in_ready) carries one word per operation: kind,
// error_code, timestamp and age. Kinds: log, log critical, read main ring,
// read critical ring, clear. Output channel (out_valid/out_ready) returns
// exactly one word per input word: ok, read_code/read_time of a read, and
// the statistics as they stand after the operation.
// Accepted words pass the stage-1 register, then the output register.
// Throughput: one word per cycle unless the receiver stalls. Each ring is a
// single-port-style memory with one write and one registered read per
// cycle; state and statistics update at the accept edge, so a read directly
// behind a log sees it. The pipeline is one memory-read stage plus an output
// register; when the receiver stalls, the stage fills and in_ready drops
// until the output register drains, so no word is lost or repeated.
// Reset (arst_n low) clears positions, fill counts, statistics, the
// 256-bit seen map and both valid flags. Ring contents are not cleared;
// slots are only read after they have been written.
module error_log_tracker_unit
	import elt_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [KIND_W-1:0]   kind,
	input  logic [CODE_W-1:0]   error_code,
	input  logic [STAMP_W-1:0]  timestamp,
	input  logic [AGE_W-1:0]    age,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                ok,
	output logic [CODE_W-1:0]   read_code,
	output logic [STAMP_W-1:0]  read_time,
	output logic [31:0]         total_errors,
	output logic [UNIQ_W-1:0]   unique_errors,
	output logic [31:0]         critical_errors,
	output logic [STAMP_W-1:0]  last_time,
	output logic [STAMP_W-1:0]  oldest_time,
	output logic [FILL_W-1:0]   stored_count
);

	// ring memories
	entry_t ring_mem [ERR_DEPTH];
	entry_t crit_mem [CRIT_DEPTH];

	// architectural state
	logic [ERR_AW-1:0]  wp_q, wp_d;
	logic [CRIT_AW-1:0] cwp_q, cwp_d;
	logic [CRIT_CW-1:0] cfill_q, cfill_d;
	stats_t             st_q, st_d;
	logic [SEEN_N-1:0]  seen_q;
	logic               seen_set;

	// pipeline
	logic   acc, adv;
	logic   valid_s1, ok_s1, rmain_s1, rcrit_s1;
	stats_t st_s1;
	entry_t ring_rd_s1, crit_rd_s1;
	logic   out_valid_q, ok_q;
	entry_t rd_q;
	stats_t st_out_q;

	// per-word decode
	logic              is_log, is_crit, is_rd, is_rdc, is_clr;
	logic              rd_hit, rdc_hit;
	logic [ERR_AW-1:0] rd_idx;
	logic [CRIT_AW-1:0] rdc_idx;
	logic              seen_bit;
	entry_t            wr_entry;

	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;
	assign acc      = in_valid && in_ready;

	always_comb begin
		is_log  = 1'b0;
		is_crit = 1'b0;
		is_rd   = 1'b0;
		is_rdc  = 1'b0;
		is_clr  = 1'b0;
		case (kind)
			KIND_LOG:       is_log  = 1'b1;
			KIND_LOG_CRIT: begin
				is_log  = 1'b1;
				is_crit = 1'b1;
			end
			KIND_READ:      is_rd   = 1'b1;
			KIND_READ_CRIT: is_rdc  = 1'b1;
			KIND_CLEAR:     is_clr  = 1'b1;
			default: ;
		endcase
	end

	// age 0 is the slot just behind the write pointer
	assign rd_hit   = is_rd && ({1'b0, age} < st_q.fill);
	assign rdc_hit  = is_rdc && (FILL_W'(age) < FILL_W'(cfill_q));
	assign rd_idx   = wp_q - ERR_AW'(1) - ERR_AW'(age);
	assign rdc_idx  = cwp_q - CRIT_AW'(1) - CRIT_AW'(age);
	assign seen_bit = seen_q[error_code[SEEN_W-1:0]];
	assign seen_set = acc && is_log && !seen_bit;
	assign wr_entry = '{code: error_code, stamp: timestamp};

	// next state of positions and statistics
	always_comb begin
		wp_d    = wp_q;
		cwp_d   = cwp_q;
		cfill_d = cfill_q;
		st_d    = st_q;
		if (is_clr) begin
			wp_d    = '0;
			cwp_d   = '0;
			cfill_d = '0;
			st_d    = '0;
		end else if (is_log) begin
			wp_d        = (wp_q == ERR_AW'(ERR_DEPTH - 1)) ? '0 : wp_q + ERR_AW'(1);
			st_d.total  = st_q.total + 32'd1;
			st_d.last   = timestamp;
			if (st_q.oldest == '0 || timestamp < st_q.oldest)
				st_d.oldest = timestamp;
			if (!seen_bit)
				st_d.uniq = st_q.uniq + UNIQ_W'(1);
			if (st_q.fill < FILL_W'(ERR_DEPTH))
				st_d.fill = st_q.fill + FILL_W'(1);
			if (is_crit) begin
				cwp_d     = (cwp_q == CRIT_AW'(CRIT_DEPTH - 1)) ? '0 : cwp_q + CRIT_AW'(1);
				st_d.crit = st_q.crit + 32'd1;
				if (cfill_q < CRIT_CW'(CRIT_DEPTH))
					cfill_d = cfill_q + CRIT_CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			cwp_q   <= '0;
			cfill_q <= '0;
			st_q    <= '0;
			seen_q  <= '0;
		end else if (acc) begin
			wp_q    <= wp_d;
			cwp_q   <= cwp_d;
			cfill_q <= cfill_d;
			st_q    <= st_d;
			if (seen_set)
				seen_q[error_code[SEEN_W-1:0]] <= 1'b1;
		end
	end

	// memories: write on log, registered read on read
	always_ff @(posedge clk) begin
		if (acc && is_log)
			ring_mem[wp_q] <= wr_entry;
		if (acc && is_rd)
			ring_rd_s1 <= ring_mem[rd_idx];
	end

	always_ff @(posedge clk) begin
		if (acc && is_crit)
			crit_mem[cwp_q] <= wr_entry;
		if (acc && is_rdc)
			crit_rd_s1 <= crit_mem[rdc_idx];
	end

	// stage 1: read data lands here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (acc)
			valid_s1 <= 1'b1;
		else if (adv)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_s1    <= is_log || is_clr || rd_hit || rdc_hit;
			rmain_s1 <= rd_hit;
			rcrit_s1 <= rdc_hit;
			st_s1    <= st_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ok_q     <= ok_s1;
			st_out_q <= st_s1;
			if (rmain_s1)
				rd_q <= ring_rd_s1;
			else if (rcrit_s1)
				rd_q <= crit_rd_s1;
			else
				rd_q <= '0;
		end
	end

	assign out_valid       = out_valid_q;
	assign ok              = ok_q;
	assign read_code       = rd_q.code;
	assign read_time       = rd_q.stamp;
	assign total_errors    = st_out_q.total;
	assign unique_errors   = st_out_q.uniq;
	assign critical_errors = st_out_q.crit;
	assign last_time       = st_out_q.last;
	assign oldest_time     = st_out_q.oldest;
	assign stored_count    = st_out_q.fill;

	// checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.fill <= FILL_W'(ERR_DEPTH) && cfill_q <= CRIT_CW'(CRIT_DEPTH))
		else $error("ring fill count beyond depth");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_clr) |=> (st_q == '0 && wp_q == '0 && cwp_q == '0 && cfill_q == '0))
		else $error("clear left state behind");

	a_log_total: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && is_log) |=> (st_q.total == $past(st_q.total) + 32'd1))
		else $error("log did not bump total");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !out_ready) |=> (valid_s1 && $stable(st_s1)))
		else $error("stage 1 word lost under stall");

	a_rd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(rmain_s1 && rcrit_s1))
		else $error("both ring reads selected");

endmodule

### tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import elt_pkg::*;

	// Kind codes the block does not define; they must leave the state alone.
	localparam logic [KIND_W-1:0] KIND_BAD_FIRST = 3'd5;
	localparam logic [KIND_W-1:0] KIND_BAD_LAST  = 3'd7;

	// Hard stop for a hung run, in ns.
	localparam int RUN_LIMIT_NS = 5_000_000;

	// One output word, laid out in port order.
	typedef struct packed {
		logic   ok;
		entry_t rd;
		stats_t st;
	} tracker_word_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [KIND_W-1:0]  kind = KIND_LOG;
	logic [CODE_W-1:0]  error_code = '0;
	logic [STAMP_W-1:0] timestamp = '0;
	logic [AGE_W-1:0]   age = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic               ok;
	logic [CODE_W-1:0]  read_code;
	logic [STAMP_W-1:0] read_time;
	logic [31:0]        total_errors;
	logic [UNIQ_W-1:0]  unique_errors;
	logic [31:0]        critical_errors;
	logic [STAMP_W-1:0] last_time;
	logic [STAMP_W-1:0] oldest_time;
	logic [FILL_W-1:0]  stored_count;

	error_log_tracker_unit i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.kind            (kind),
		.error_code      (error_code),
		.timestamp       (timestamp),
		.age             (age),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.ok              (ok),
		.read_code       (read_code),
		.read_time       (read_time),
		.total_errors    (total_errors),
		.unique_errors   (unique_errors),
		.critical_errors (critical_errors),
		.last_time       (last_time),
		.oldest_time     (oldest_time),
		.stored_count    (stored_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Shadow copy of the tracker state (reset values at time zero).
	// Ring contents start at zero; a slot is only ever read once written.
	// ------------------------------------------------------------------
	logic [CODE_W-1:0]  main_code  [ERR_DEPTH]  = '{default: '0};
	logic [STAMP_W-1:0] main_stamp [ERR_DEPTH]  = '{default: '0};
	logic [CODE_W-1:0]  crit_code  [CRIT_DEPTH] = '{default: '0};
	logic [STAMP_W-1:0] crit_stamp [CRIT_DEPTH] = '{default: '0};
	logic [ERR_AW-1:0]  main_head = '0;
	logic [FILL_W-1:0]  main_fill = '0;
	logic [CRIT_AW-1:0] crit_head = '0;
	logic [CRIT_CW-1:0] crit_fill = '0;
	logic [31:0]        n_logged = '0;
	logic [31:0]        n_crit = '0;
	logic [UNIQ_W-1:0]  n_unique = '0;
	logic [STAMP_W-1:0] stamp_newest = '0;
	logic [STAMP_W-1:0] stamp_oldest = '0;
	logic [SEEN_N-1:0]  seen_bytes = '0;

	// Words accepted by the block whose output has not come back yet.
	tracker_word_t awaited_words[$];
	tracker_word_t got_word, want_word;

	int  fail_count = 0;
	int  words_out = 0;
	bit  src_gaps = 1'b1;     // sender inserts random idle cycles
	bit  sink_stalls = 1'b1;  // receiver drops ready at random
	int  hold_req = 0;        // long receiver hold-off, in cycles
	int  hold_left = 0;
	logic [STAMP_W-1:0] stamp_clock = '0;

	// Apply one operation to the shadow state and return the word the
	// block should produce for it. Statistics reflect the state after.
	function automatic tracker_word_t apply_op(input logic [KIND_W-1:0] op,
			input logic [CODE_W-1:0] c, input logic [STAMP_W-1:0] s,
			input logic [AGE_W-1:0] a);
		tracker_word_t w;
		logic [ERR_AW-1:0]  mi;
		logic [CRIT_AW-1:0] ci;
		w = '0;
		case (op)
		KIND_LOG, KIND_LOG_CRIT: begin
			main_code[main_head]  = c;
			main_stamp[main_head] = s;
			main_head = main_head + 1'b1;
			if (main_fill < ERR_DEPTH)
				main_fill = main_fill + 1'b1;
			n_logged = n_logged + 1;
			stamp_newest = s;
			// zero oldest means "nothing logged yet"
			if (stamp_oldest == '0 || s < stamp_oldest)
				stamp_oldest = s;
			// unique count tracks first sightings of the low byte only
			if (!seen_bytes[c[7:0]]) begin
				seen_bytes[c[7:0]] = 1'b1;
				n_unique = n_unique + 1'b1;
			end
			if (op == KIND_LOG_CRIT) begin
				crit_code[crit_head]  = c;
				crit_stamp[crit_head] = s;
				crit_head = crit_head + 1'b1;
				if (crit_fill < CRIT_DEPTH)
					crit_fill = crit_fill + 1'b1;
				n_crit = n_crit + 1;
			end
			w.ok = 1'b1;
		end
		KIND_READ: begin
			if (a < main_fill) begin
				mi = main_head - 1'b1 - a;
				w.rd = '{main_code[mi], main_stamp[mi]};
				w.ok = 1'b1;
			end
		end
		KIND_READ_CRIT: begin
			if (a < crit_fill) begin
				ci = crit_head - 1'b1 - a;
				w.rd = '{crit_code[ci], crit_stamp[ci]};
				w.ok = 1'b1;
			end
		end
		KIND_CLEAR: begin
			// seen_bytes survives a clear on purpose
			main_head = '0;
			main_fill = '0;
			crit_head = '0;
			crit_fill = '0;
			n_logged = '0;
			n_crit = '0;
			n_unique = '0;
			stamp_newest = '0;
			stamp_oldest = '0;
			w.ok = 1'b1;
		end
		default: begin
		end
		endcase
		w.st = '{n_logged, n_unique, n_crit, stamp_newest, stamp_oldest, main_fill};
		return w;
	endfunction

	// Offer one word. Valid stays up from the previous word unless a gap
	// is drawn, so each step sees at most one update of in_valid.
	task automatic offer_word(input logic [KIND_W-1:0] op, input logic [CODE_W-1:0] c,
			input logic [STAMP_W-1:0] s, input logic [AGE_W-1:0] a);
		int gap;
		gap = 0;
		if (src_gaps)
			while ($urandom_range(0, 99) < 31)
				gap++;
		repeat (gap) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= op;
		error_code <= c;
		timestamp  <= s;
		age        <= a;
		@(posedge clk);
		while (in_ready !== 1'b1)
			@(posedge clk);
		awaited_words.push_back(apply_op(op, c, s, a));
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got_v,
			input logic [31:0] want_v);
		if (fail_count < 40)
			$display("mismatch on output word %0d: %s got %h expected %h",
				words_out, what, got_v, want_v);
		fail_count++;
	endtask

	// Mostly a rising clock, with zero, all-ones and arbitrary values mixed in.
	function automatic logic [STAMP_W-1:0] pick_stamp();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return '0;
		if (r < 10)
			return '1;
		if (r < 20)
			return $urandom;
		stamp_clock = stamp_clock + $urandom_range(1, 1000);
		return stamp_clock;
	endfunction

	function automatic logic [CODE_W-1:0] pick_code();
		logic [CODE_W-1:0] c;
		c = $urandom;
		// half the codes reuse a handful of low bytes
		if ($urandom_range(0, 1) == 0)
			c[7:0] = 8'($urandom_range(0, 15));
		return c;
	endfunction

	// Random word: logs and reads dominate, reads mostly hit stored entries.
	task automatic random_word();
		int r;
		logic [KIND_W-1:0] op;
		logic [AGE_W-1:0]  a;
		r = $urandom_range(0, 999);
		a = AGE_W'($urandom_range(0, 31));
		if (r < 350)
			op = KIND_LOG;
		else if (r < 550)
			op = KIND_LOG_CRIT;
		else if (r < 800) begin
			op = KIND_READ;
			if (main_fill != 0 && $urandom_range(0, 3) != 0)
				a = AGE_W'($urandom_range(0, main_fill - 1));
		end else if (r < 970) begin
			op = KIND_READ_CRIT;
			if (crit_fill != 0 && $urandom_range(0, 3) != 0)
				a = AGE_W'($urandom_range(0, crit_fill - 1));
		end else if (r < 985)
			op = KIND_CLEAR;
		else
			op = KIND_W'($urandom_range(KIND_BAD_FIRST, KIND_BAD_LAST));
		offer_word(op, pick_code(), pick_stamp(), a);
	endtask

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Empty reads, field extremes, read right behind a log, failed reads
	// past the fill count, and undefined kinds.
	task automatic test_directed();
		src_gaps = 1'b0;
		offer_word(KIND_READ, '0, '0, '0);
		offer_word(KIND_READ, '1, '1, '1);
		offer_word(KIND_READ_CRIT, '0, '0, '0);
		offer_word(KIND_LOG, '0, '0, '0);           // zero stamp keeps oldest empty
		offer_word(KIND_READ, '0, '0, '0);
		offer_word(KIND_LOG, '1, '1, '0);
		offer_word(KIND_LOG_CRIT, 32'h5a5a_5a00, 32'd1, '0);  // low byte already seen
		offer_word(KIND_LOG, 32'h0000_00ff, 32'd7, '0);
		offer_word(KIND_READ, '0, '0, 5'd3);
		offer_word(KIND_READ, '0, '0, 5'd4);
		offer_word(KIND_READ, '0, '0, 5'd1);
		offer_word(KIND_READ_CRIT, '0, '0, 5'd0);
		offer_word(KIND_READ_CRIT, '0, '0, 5'd1);
		offer_word(KIND_READ_CRIT, '0, '0, '1);
		for (int k = KIND_BAD_FIRST; k <= KIND_BAD_LAST; k++)
			offer_word(KIND_W'(k), $urandom, $urandom, AGE_W'($urandom_range(0, 31)));
		offer_word(KIND_READ, '0, '0, 5'd0);
		src_gaps = 1'b1;
	endtask

	// Every low byte once, before any clear, so unique_errors reaches 256.
	task automatic test_seen_sweep();
		logic [CODE_W-1:0] c;
		for (int b = 0; b < SEEN_N; b++) begin
			c = $urandom;
			c[7:0] = 8'(b);
			offer_word(KIND_LOG, c, pick_stamp(), '0);
		end
		offer_word(KIND_READ, '0, '0, '1);
		offer_word(KIND_READ_CRIT, '0, '0, '0);
	endtask

	// Clear empties both rings and the statistics but keeps the seen map.
	task automatic test_clear();
		offer_word(KIND_CLEAR, $urandom, $urandom, AGE_W'($urandom_range(0, 31)));
		offer_word(KIND_READ, '0, '0, 5'd0);
		offer_word(KIND_READ_CRIT, '0, '0, 5'd0);
		offer_word(KIND_LOG, 32'h1234_5642, 32'd100, '0);
		offer_word(KIND_LOG_CRIT, 32'h0000_0042, 32'd50, '0);
		offer_word(KIND_READ, '0, '0, 5'd1);
		offer_word(KIND_CLEAR, '0, '0, '0);
	endtask

	// Fill both rings past their depth; fill counts must saturate.
	task automatic test_saturation();
		repeat (40)
			offer_word(KIND_LOG_CRIT, pick_code(), pick_stamp(), '0);
		offer_word(KIND_READ, '0, '0, 5'd31);
		offer_word(KIND_READ, '0, '0, 5'd0);
		offer_word(KIND_READ_CRIT, '0, '0, 5'd7);
		offer_word(KIND_READ_CRIT, '0, '0, 5'd8);
	endtask

	task automatic test_random_mix(input int n);
		repeat (n)
			random_word();
	endtask

	// Full rate on both sides.
	task automatic test_back_to_back(input int n);
		src_gaps = 1'b0;
		sink_stalls = 1'b0;
		repeat (n)
			random_word();
		src_gaps = 1'b1;
		sink_stalls = 1'b1;
	endtask

	// Receiver holds off while the sender keeps offering; in_ready must drop
	// and nothing may be lost once the hold ends.
	task automatic test_backpressure(input int hold_cycles, input int n);
		src_gaps = 1'b0;
		hold_req = hold_cycles;
		repeat (n)
			random_word();
		src_gaps = 1'b1;
	endtask

	// ------------------------------------------------------------------
	// Receiver ready: random stalls plus a counted hold-off on request.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req != 0) begin
			hold_left = hold_req;
			hold_req = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (sink_stalls && $urandom_range(0, 99) < 31)
			out_ready <= 1'b0;
		else
			out_ready <= 1'b1;
	end

	// Checker: each accepted output word against the oldest awaited word.
	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			got_word = {ok, read_code, read_time, total_errors, unique_errors,
				critical_errors, last_time, oldest_time, stored_count};
			if (awaited_words.size() == 0)
				report_mismatch("word with nothing awaited, total_errors",
					total_errors, '0);
			else begin
				want_word = awaited_words.pop_front();
				if (got_word.ok !== want_word.ok)
					report_mismatch("ok", 32'(got_word.ok), 32'(want_word.ok));
				if (got_word.rd.code !== want_word.rd.code)
					report_mismatch("read_code", got_word.rd.code, want_word.rd.code);
				if (got_word.rd.stamp !== want_word.rd.stamp)
					report_mismatch("read_time", got_word.rd.stamp, want_word.rd.stamp);
				if (got_word.st.total !== want_word.st.total)
					report_mismatch("total_errors", got_word.st.total, want_word.st.total);
				if (got_word.st.uniq !== want_word.st.uniq)
					report_mismatch("unique_errors", 32'(got_word.st.uniq),
						32'(want_word.st.uniq));
				if (got_word.st.crit !== want_word.st.crit)
					report_mismatch("critical_errors", got_word.st.crit, want_word.st.crit);
				if (got_word.st.last !== want_word.st.last)
					report_mismatch("last_time", got_word.st.last, want_word.st.last);
				if (got_word.st.oldest !== want_word.st.oldest)
					report_mismatch("oldest_time", got_word.st.oldest, want_word.st.oldest);
				if (got_word.st.fill !== want_word.st.fill)
					report_mismatch("stored_count", 32'(got_word.st.fill),
						32'(want_word.st.fill));
			end
			words_out++;
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_seen_sweep();       // must precede the first clear
		test_clear();
		test_saturation();
		test_random_mix(600);
		test_backpressure(80, 30);
		test_back_to_back(300);
		test_random_mix(500);
		test_backpressure(120, 40);

		// drain: wait for every awaited word, then watch for strays
		in_valid <= 1'b0;
		while (awaited_words.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
